// File: design/assert_macros.svh
// assertion helpers included by the validator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, held off while reset is asserted
`define CHK_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define CHK_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/pngv_pkg.sv
// ---------------------------------------------------------------------------
// pngv_pkg
// Types, chunk codes and crc helper for the png chunk stream validator.
// ---------------------------------------------------------------------------
package pngv_pkg;

  // chunk type codes
  localparam logic [31:0] T_IHDR = 32'h4948_4452;
  localparam logic [31:0] T_PLTE = 32'h504C_5445;
  localparam logic [31:0] T_IDAT = 32'h4944_4154;
  localparam logic [31:0] T_IEND = 32'h4945_4E44;
  localparam logic [31:0] T_TRNS = 32'h7452_4E53;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [9:0]  PLTE_MAX = 10'd768;
  localparam logic [31:0] IHDR_LEN = 32'd13;

  // final status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_SIG = 3'd1,
    ST_BAD_CHK = 3'd2,
    ST_BAD_CRC = 3'd3,
    ST_UNSUP   = 3'd4,
    ST_BUFFER  = 3'd5
  } status_t;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_SIG  = 6'b000001,
    PH_LEN  = 6'b000010,
    PH_TYPE = 6'b000100,
    PH_DATA = 6'b001000,
    PH_CRC  = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  // seen chunk flags
  typedef struct packed {
    logic fend;
    logic dend;
    logic data;
    logic trns;
    logic pal;
    logic hdr;
  } seen_t;

  // register addresses (word index)
  localparam logic REG_COPY = 1'b0;
  localparam logic REG_CAP  = 1'b1;

  // png file signature
  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0: b = 8'h89;
      3'd1: b = 8'h50;
      3'd2: b = 8'h4E;
      3'd3: b = 8'h47;
      3'd4: b = 8'h0D;
      3'd5: b = 8'h0A;
      3'd6: b = 8'h1A;
      default: b = 8'h0A;
    endcase
    return b;
  endfunction

  // one byte of reflected crc-32
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // samples per pixel for a colour type
  function automatic logic [2:0] channels_of(input logic [7:0] ct);
    logic [2:0] n;
    unique case (ct)
      8'd0: n = 3'd1;
      8'd2: n = 3'd3;
      8'd3: n = 3'd1;
      8'd4: n = 3'd2;
      8'd6: n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// File: design/png_chunk_stream_validator.sv
// ---------------------------------------------------------------------------
// png_chunk_stream_validator
// Byte stream png parser: signature, chunk split, crc-32 and chunk rules.
// ---------------------------------------------------------------------------
// Takes one file byte per cycle on in_* and accepts a new byte every cycle as
// long as the output register is free or being drained; the single-byte crc
// step and the chunk rule compares sit between the parser state and the output
// register. The result transaction of an accepted byte is registered and comes
// out in the cycle after the byte is accepted. With copy_enable set, IDAT
// payload bytes come out as kind 0 transactions; every file ends in exactly
// one kind 1 status transaction carrying the IHDR fields and counts. After an
// error status the remaining bytes up to tlast are swallowed.
module png_chunk_stream_validator
  import pngv_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: [7:0] in_byte
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,
  input  logic         in_tlast,
  // out_tdata: [7:0] payload_byte, [10:8] status, [42:11] img_width,
  // [74:43] img_height, [82:75] depth_bits, [90:83] colour_kind,
  // [93:91] channel_count, [94] interlaced, [103:95] palette_entries,
  // [112:104] alpha_bytes, [144:113] compressed_total, rest zero
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,
  // out_tuser: [0] kind
  output logic         out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

`include "assert_macros.svh"

  localparam int SW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

  // config registers
  logic        copy_enable_r;
  logic [31:0] payload_capacity_r;

  // parser state
  phase_t                phase_r, phase_nxt;
  logic [31:0]           byte_index_r, byte_index_nxt;
  logic [31:0]           chunk_length_r, chunk_length_nxt;
  logic [31:0]           chunk_type_r, chunk_type_nxt;
  logic [31:0]           running_crc_r, running_crc_nxt;
  logic [31:0]           stored_crc_r, stored_crc_nxt;
  seen_t                 seen_r, seen_nxt;
  logic [7:0]            header_r [13];
  logic [8:0]            palette_count_r, palette_count_nxt;
  logic [8:0]            alpha_count_r, alpha_count_nxt;
  logic [COUNT_BITS-1:0] payload_count_r, payload_count_nxt;
  status_t               pending_r, pending_nxt;
  logic [63:0]           area_r;

  // output register
  logic        out_valid_r;
  logic        out_kind_r;
  logic [7:0]  out_byte_r;
  status_t     out_status_r;
  logic [31:0] out_width_r, out_height_r;
  logic [7:0]  out_depth_r, out_colour_r;
  logic [2:0]  out_chan_r;
  logic        out_ilace_r;
  logic [8:0]  out_pal_r, out_alpha_r;
  logic [31:0] out_total_r;

  logic in_acc;
  logic hdr_wr;
  logic [3:0] hdr_idx;

  // result of the current byte
  logic    emit, emit_kind, do_restart, do_done;
  status_t emit_st;

  // ihdr fields
  logic [31:0] hw, hh;
  logic [7:0]  hd, hct;
  logic        low_depth, depth_ok, hdr_bad, area_big;

  // idat counter and capacity
  logic [SW-1:0] pc_sum;
  logic          pc_ovf, cap_over;

  // plte arithmetic on lengths up to 768
  logic [20:0] q_mul;
  logic [8:0]  len_div3;
  logic [9:0]  len_rem;
  logic        len_small;

  // chunk end evaluation
  status_t ce_st;
  seen_t   ce_seen;
  logic [8:0] ce_pal, ce_alpha;
  logic [COUNT_BITS-1:0] ce_pc;
  status_t fin_st;
  logic crc_bad;
  logic [31:0] crc_step;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  // apb port
  assign cfg_pready = 1'b1;
  always_comb begin
    unique case (cfg_paddr[2])
      REG_COPY: cfg_prdata = {31'd0, copy_enable_r};
      REG_CAP:  cfg_prdata = payload_capacity_r;
      default:  cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_enable_r      <= 1'b0;
      payload_capacity_r <= 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_COPY) copy_enable_r <= cfg_pwdata[0];
      else payload_capacity_r <= cfg_pwdata;
    end
  end

  // ihdr decode
  assign hw  = {header_r[0], header_r[1], header_r[2], header_r[3]};
  assign hh  = {header_r[4], header_r[5], header_r[6], header_r[7]};
  assign hd  = header_r[8];
  assign hct = header_r[9];
  assign low_depth = (hd == 8'd1) || (hd == 8'd2) || (hd == 8'd4) || (hd == 8'd8);
  always_comb begin
    unique case (hct)
      8'd0:                depth_ok = low_depth || (hd == 8'd16);
      8'd3:                depth_ok = low_depth;
      8'd2, 8'd4, 8'd6:    depth_ok = (hd == 8'd8) || (hd == 8'd16);
      default:             depth_ok = 1'b0;
    endcase
  end
  assign area_big = |area_r[63:COUNT_BITS-2];
  assign hdr_bad  = (hw == 32'd0) || (hh == 32'd0) || !depth_ok ||
                    (header_r[10] != 8'd0) || (header_r[11] != 8'd0) ||
                    (header_r[12] > 8'd1) || area_big;

  // pixel count product, registered; header is stable well before crc end
  always_ff @(posedge clk) begin
    area_r <= {32'd0, hw} * {32'd0, hh};
  end

  // idat payload total against counter range and capacity
  assign pc_sum   = SW'(payload_count_r) + SW'(chunk_length_r);
  assign pc_ovf   = |pc_sum[SW-1:COUNT_BITS];
  assign cap_over = copy_enable_r && (pc_sum > SW'(payload_capacity_r));

  // divide by three through a reciprocal, exact below 769
  assign len_small = (chunk_length_r <= {22'd0, PLTE_MAX});
  assign q_mul     = 21'(chunk_length_r[9:0]) * 21'd683;
  assign len_div3  = q_mul[19:11];
  assign len_rem   = chunk_length_r[9:0] - 10'(len_div3) * 10'd3;

  assign crc_step = crc_byte(running_crc_r, in_tdata);
  assign crc_bad  = (running_crc_r ^ CRC_INIT) != {stored_crc_r[23:0], in_tdata};

  // rules applied on the last crc byte of a chunk
  always_comb begin
    ce_st    = ST_OK;
    ce_seen  = seen_r;
    ce_pal   = palette_count_r;
    ce_alpha = alpha_count_r;
    ce_pc    = payload_count_r;
    priority if (crc_bad) begin
      ce_st = ST_BAD_CRC;
    end else if (pending_r != ST_OK) begin
      ce_st = pending_r;
    end else if (!seen_r.hdr && chunk_type_r != T_IHDR) begin
      ce_st = ST_BAD_CHK;
    end else if (chunk_type_r == T_IHDR) begin
      if (seen_r.hdr || chunk_length_r != IHDR_LEN) ce_st = ST_BAD_CHK;
      else if (hdr_bad) ce_st = ST_UNSUP;
      else ce_seen.hdr = 1'b1;
    end else if (chunk_type_r == T_PLTE) begin
      if (seen_r.pal || seen_r.data || chunk_length_r == 32'd0 || !len_small ||
          len_rem != 10'd0 || hct == 8'd0 || hct == 8'd4 ||
          (hct == 8'd3 && (hd >= 8'd16 || 17'(len_div3) > (17'd1 << hd[3:0])))) begin
        ce_st = ST_BAD_CHK;
      end else begin
        ce_seen.pal = 1'b1;
        ce_pal      = len_div3;
      end
    end else if (chunk_type_r == T_TRNS) begin
      if (seen_r.trns || seen_r.data ||
          !((hct == 8'd0 && chunk_length_r == 32'd2) ||
            (hct == 8'd2 && chunk_length_r == 32'd6) ||
            (hct == 8'd3 && seen_r.pal && chunk_length_r != 32'd0 &&
             chunk_length_r <= {23'd0, palette_count_r}))) begin
        ce_st = ST_BAD_CHK;
      end else begin
        ce_seen.trns = 1'b1;
        ce_alpha     = chunk_length_r[8:0];
      end
    end else if (chunk_type_r == T_IDAT) begin
      ce_seen.data = 1'b1;
      ce_pc        = pc_sum[COUNT_BITS-1:0];
    end else if (chunk_type_r == T_IEND) begin
      if (!seen_r.data || chunk_length_r != 32'd0) ce_st = ST_BAD_CHK;
      else ce_seen.fend = 1'b1;
    end else if (!chunk_type_r[29]) begin
      ce_st = ST_UNSUP;
    end else begin
      ce_st = ST_OK;
    end
    if (ce_st == ST_OK && ce_seen.data && chunk_type_r != T_IDAT &&
        chunk_type_r != T_IEND) begin
      ce_seen.dend = 1'b1;
    end
  end

  // end of file rules
  always_comb begin
    if (payload_count_r == '0) fin_st = ST_BAD_CHK;
    else if (hct == 8'd3 && (!seen_r.pal || alpha_count_r > palette_count_r))
      fin_st = ST_BAD_CHK;
    else fin_st = ST_OK;
  end

  // per byte parser step
  always_comb begin
    phase_nxt         = phase_r;
    byte_index_nxt    = byte_index_r;
    chunk_length_nxt  = chunk_length_r;
    chunk_type_nxt    = chunk_type_r;
    running_crc_nxt   = running_crc_r;
    stored_crc_nxt    = stored_crc_r;
    seen_nxt          = seen_r;
    palette_count_nxt = palette_count_r;
    alpha_count_nxt   = alpha_count_r;
    payload_count_nxt = payload_count_r;
    pending_nxt       = pending_r;
    emit       = 1'b0;
    emit_kind  = 1'b1;
    emit_st    = ST_OK;
    do_restart = 1'b0;
    do_done    = 1'b0;
    hdr_wr     = 1'b0;
    hdr_idx    = byte_index_r[3:0];
    unique case (phase_r)
      PH_SIG: begin
        if (in_tdata != sig_byte(byte_index_r[2:0])) begin
          emit = 1'b1; emit_st = ST_BAD_SIG;
        end else if (byte_index_r[2:0] == 3'd7) begin
          if (in_tlast) begin
            emit = 1'b1; emit_st = ST_BAD_CHK;
          end else begin
            phase_nxt = PH_LEN; byte_index_nxt = 32'd0;
          end
        end else if (in_tlast) begin
          emit = 1'b1; emit_st = ST_BAD_SIG;
        end else begin
          byte_index_nxt = byte_index_r + 32'd1;
        end
      end
      PH_LEN: begin
        chunk_length_nxt = {chunk_length_r[23:0], in_tdata};
        byte_index_nxt   = byte_index_r + 32'd1;
        if (byte_index_r[1:0] == 2'd3) begin
          phase_nxt = PH_TYPE; byte_index_nxt = 32'd0; running_crc_nxt = CRC_INIT;
        end
        if (in_tlast) begin
          emit = 1'b1; emit_st = ST_BAD_CHK;
        end
      end
      PH_TYPE: begin
        chunk_type_nxt  = {chunk_type_r[23:0], in_tdata};
        running_crc_nxt = crc_step;
        byte_index_nxt  = byte_index_r + 32'd1;
        if (byte_index_r[1:0] == 2'd3) begin
          if (chunk_type_nxt != T_IDAT) pending_nxt = ST_OK;
          else if (!seen_r.hdr || seen_r.dend) pending_nxt = ST_BAD_CHK;
          else if (pc_ovf) pending_nxt = ST_UNSUP;
          else if (cap_over) pending_nxt = ST_BUFFER;
          else pending_nxt = ST_OK;
          phase_nxt      = (chunk_length_r != 32'd0) ? PH_DATA : PH_CRC;
          byte_index_nxt = 32'd0;
        end
        if (in_tlast) begin
          emit = 1'b1; emit_st = ST_BAD_CHK;
        end
      end
      PH_DATA: begin
        running_crc_nxt = crc_step;
        hdr_wr = (chunk_type_r == T_IHDR) && !seen_r.hdr && (byte_index_r < IHDR_LEN);
        byte_index_nxt = byte_index_r + 32'd1;
        if (byte_index_nxt >= chunk_length_r) begin
          phase_nxt = PH_CRC; byte_index_nxt = 32'd0;
        end
        if (in_tlast) begin
          emit = 1'b1; emit_st = ST_BAD_CHK;
        end else if (chunk_type_r == T_IDAT && pending_r == ST_OK && copy_enable_r) begin
          emit = 1'b1; emit_kind = 1'b0;
        end
      end
      PH_CRC: begin
        stored_crc_nxt = {stored_crc_r[23:0], in_tdata};
        byte_index_nxt = byte_index_r + 32'd1;
        if (byte_index_r[1:0] != 2'd3) begin
          if (in_tlast) begin
            emit = 1'b1; emit_st = ST_BAD_CHK;
          end
        end else begin
          seen_nxt          = ce_seen;
          palette_count_nxt = ce_pal;
          alpha_count_nxt   = ce_alpha;
          payload_count_nxt = ce_pc;
          if (ce_st != ST_OK) begin
            emit = 1'b1; emit_st = ce_st;
          end else if (chunk_type_r == T_IEND) begin
            emit = 1'b1; emit_st = in_tlast ? fin_st : ST_BAD_CHK;
          end else if (in_tlast) begin
            emit = 1'b1; emit_st = ST_BAD_CHK;
          end else begin
            phase_nxt        = PH_LEN;
            byte_index_nxt   = 32'd0;
            chunk_length_nxt = 32'd0;
            chunk_type_nxt   = 32'd0;
            stored_crc_nxt   = 32'd0;
            pending_nxt      = ST_OK;
          end
        end
      end
      PH_DONE: begin
        do_restart = in_tlast;
      end
      default: begin
        do_restart = 1'b1;
      end
    endcase
    if (emit && emit_kind) begin
      do_restart = in_tlast;
      do_done    = !in_tlast;
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_SIG;
      byte_index_r    <= 32'd0;
      chunk_length_r  <= 32'd0;
      chunk_type_r    <= 32'd0;
      running_crc_r   <= CRC_INIT;
      stored_crc_r    <= 32'd0;
      seen_r          <= '0;
      palette_count_r <= 9'd0;
      alpha_count_r   <= 9'd0;
      payload_count_r <= '0;
      pending_r       <= ST_OK;
    end else if (in_acc) begin
      if (do_restart) begin
        phase_r         <= PH_SIG;
        byte_index_r    <= 32'd0;
        chunk_length_r  <= 32'd0;
        chunk_type_r    <= 32'd0;
        running_crc_r   <= CRC_INIT;
        stored_crc_r    <= 32'd0;
        seen_r          <= '0;
        palette_count_r <= 9'd0;
        alpha_count_r   <= 9'd0;
        payload_count_r <= '0;
        pending_r       <= ST_OK;
      end else begin
        phase_r         <= do_done ? PH_DONE : phase_nxt;
        byte_index_r    <= byte_index_nxt;
        chunk_length_r  <= chunk_length_nxt;
        chunk_type_r    <= chunk_type_nxt;
        running_crc_r   <= running_crc_nxt;
        stored_crc_r    <= stored_crc_nxt;
        seen_r          <= seen_nxt;
        palette_count_r <= palette_count_nxt;
        alpha_count_r   <= alpha_count_nxt;
        payload_count_r <= payload_count_nxt;
        pending_r       <= pending_nxt;
      end
    end
  end

  // ihdr byte store
  always_ff @(posedge clk) begin
    if (in_acc && hdr_wr) header_r[hdr_idx] <= in_tdata;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_kind_r   <= emit_kind;
      out_byte_r   <= emit_kind ? 8'd0 : in_tdata;
      out_status_r <= emit_kind ? emit_st : ST_OK;
      out_width_r  <= (emit_kind && seen_nxt.hdr) ? hw : 32'd0;
      out_height_r <= (emit_kind && seen_nxt.hdr) ? hh : 32'd0;
      out_depth_r  <= (emit_kind && seen_nxt.hdr) ? hd : 8'd0;
      out_colour_r <= (emit_kind && seen_nxt.hdr) ? hct : 8'd0;
      out_chan_r   <= (emit_kind && seen_nxt.hdr) ? channels_of(hct) : 3'd0;
      out_ilace_r  <= emit_kind && seen_nxt.hdr && header_r[12][0];
      out_pal_r    <= emit_kind ? palette_count_nxt : 9'd0;
      out_alpha_r  <= emit_kind ? alpha_count_nxt : 9'd0;
      out_total_r  <= emit_kind ? 32'(payload_count_nxt) : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {7'd0, out_total_r, out_alpha_r, out_pal_r, out_ilace_r, out_chan_r,
                       out_colour_r, out_depth_r, out_height_r, out_width_r,
                       out_status_r, out_byte_r};

  // checks
  `CHK_CLK(a_out_from_in, clk, rst_n, $rose(out_valid_r) |-> $past(in_acc), "result without input")
  `CHK_CLK(a_last_restarts, clk, rst_n, (in_acc && in_tlast) |=> phase_r == PH_SIG, "no restart after last byte")
  `CHK_CLK(a_copy_only, clk, rst_n, (out_valid_r && !out_kind_r) |-> copy_enable_r, "payload passed while copy off")

endmodule

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the png chunk stream validator: streams whole png
// files (well-formed, damaged and random noise) byte by byte, predicts every
// payload and status transaction in a behavioral parser and compares them
// field by field against the block's result stream.
// ---------------------------------------------------------------------------
module tb;
  import pngv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // parser phases of the predictor
  typedef enum int {P_SIG, P_LEN, P_TYPE, P_DATA, P_CRC, P_DONE} pphase_t;

  // one result transaction as seen on the output
  typedef struct packed {
    logic         kind;
    logic [151:0] data;
  } result_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;
  logic         out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  png_chunk_stream_validator dut (.*);

  // pending bytes, each {last, byte}
  logic [8:0]  byte_queue[$];
  result_t     expected_results[$];
  int          error_count;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  // input transaction taken at the last rising edge
  logic        in_accepted;

  // predictor state
  logic        m_copy;
  logic [31:0] m_cap;
  pphase_t     m_phase;
  int unsigned m_idx;
  logic [31:0] m_len, m_type, m_crc, m_stored;
  logic        f_hdr, f_pal, f_trns, f_data, f_dend;
  logic [7:0]  m_hdr[13];
  logic [8:0]  m_pal, m_alpha;
  logic [32:0] m_payload;
  logic [2:0]  m_pending;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [7:0] sig_at(int i);
    logic [7:0] s[8];
    s = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    return s[i];
  endfunction

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  function automatic logic [31:0] hdr_word(int at);
    return {m_hdr[at], m_hdr[at+1], m_hdr[at+2], m_hdr[at+3]};
  endfunction

  function automatic logic [2:0] samples_for(logic [7:0] ct);
    case (ct)
      8'd0, 8'd3: return 3'd1;
      8'd2: return 3'd3;
      8'd4: return 3'd2;
      8'd6: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  task automatic restart_parser();
    m_phase = P_SIG; m_idx = 0; m_len = 0; m_type = 0; m_crc = CRC_INIT;
    m_stored = 0; {f_hdr, f_pal, f_trns, f_data, f_dend} = '0;
    foreach (m_hdr[i]) m_hdr[i] = 8'd0;
    m_pal = 0; m_alpha = 0; m_payload = 0; m_pending = 0;
  endtask

  task automatic push_status(status_t st, logic last);
    result_t r;
    r.kind = 1'b1;
    r.data = '0;
    r.data[10:8] = st;
    if (f_hdr) begin
      r.data[42:11] = hdr_word(0);
      r.data[74:43] = hdr_word(4);
      r.data[82:75] = m_hdr[8];
      r.data[90:83] = m_hdr[9];
      r.data[93:91] = samples_for(m_hdr[9]);
      r.data[94] = m_hdr[12][0];
    end
    r.data[103:95] = m_pal;
    r.data[112:104] = m_alpha;
    r.data[144:113] = m_payload[31:0];
    expected_results.push_back(r);
    if (last) restart_parser();
    else m_phase = P_DONE;
  endtask

  function automatic status_t header_verdict();
    logic [31:0] w, h;
    logic [7:0] d, ct;
    logic low, ok;
    w = hdr_word(0); h = hdr_word(4); d = m_hdr[8]; ct = m_hdr[9];
    low = (d == 1 || d == 2 || d == 4 || d == 8);
    case (ct)
      8'd0: ok = low || d == 16;
      8'd3: ok = low;
      8'd2, 8'd4, 8'd6: ok = (d == 8 || d == 16);
      default: ok = 1'b0;
    endcase
    if (w == 0 || h == 0 || !ok || m_hdr[10] != 0 || m_hdr[11] != 0 || m_hdr[12] > 1)
      return ST_UNSUP;
    if ({32'd0, w} * {32'd0, h} > 64'h3FFF_FFFF) return ST_UNSUP;
    return ST_OK;
  endfunction

  function automatic logic [2:0] idat_verdict();
    logic [32:0] nxt;
    if (!f_hdr || f_dend) return ST_BAD_CHK;
    nxt = m_payload + {1'b0, m_len};
    if (nxt[32]) return ST_UNSUP;
    if (m_copy && nxt[31:0] > m_cap) return ST_BUFFER;
    return ST_OK;
  endfunction

  // chunk rules applied at the last crc byte
  function automatic status_t chunk_verdict();
    logic [7:0] ct, d;
    status_t st;
    ct = m_hdr[9]; d = m_hdr[8];
    if ((m_crc ^ CRC_INIT) != m_stored) return ST_BAD_CRC;
    if (m_pending != 0) return status_t'(m_pending);
    if (!f_hdr && m_type != T_IHDR) return ST_BAD_CHK;
    if (m_type == T_IHDR) begin
      if (f_hdr || m_len != IHDR_LEN) return ST_BAD_CHK;
      st = header_verdict();
      if (st != ST_OK) return st;
      f_hdr = 1'b1;
    end else if (m_type == T_PLTE) begin
      if (f_pal || f_data || m_len == 0 || m_len > 768 || m_len % 3 != 0 || ct == 0 ||
          ct == 4 || (ct == 3 && (d >= 16 || m_len / 3 > (32'd1 << d))))
        return ST_BAD_CHK;
      f_pal = 1'b1;
      m_pal = 9'(m_len / 3);
    end else if (m_type == T_TRNS) begin
      if (f_trns || f_data) return ST_BAD_CHK;
      if (!((ct == 0 && m_len == 2) || (ct == 2 && m_len == 6) ||
            (ct == 3 && f_pal && m_len != 0 && m_len <= m_pal)))
        return ST_BAD_CHK;
      f_trns = 1'b1;
      m_alpha = m_len[8:0];
    end else if (m_type == T_IDAT) begin
      f_data = 1'b1;
      m_payload = m_payload + {1'b0, m_len};
    end else if (m_type == T_IEND) begin
      if (!f_data || m_len != 0) return ST_BAD_CHK;
    end else if (m_type[29] == 1'b0) begin
      return ST_UNSUP;
    end
    if (f_data && m_type != T_IDAT && m_type != T_IEND) f_dend = 1'b1;
    return ST_OK;
  endfunction

  // predict the results of one accepted byte
  task automatic predict_byte(logic [7:0] b, logic last);
    logic pass;
    result_t r;
    status_t st;
    case (m_phase)
      P_SIG: begin
        if (b != sig_at(m_idx)) push_status(ST_BAD_SIG, last);
        else if (m_idx >= 7) begin
          if (last) push_status(ST_BAD_CHK, 1'b1);
          else begin m_phase = P_LEN; m_idx = 0; end
        end else if (last) push_status(ST_BAD_SIG, 1'b1);
        else m_idx++;
      end
      P_LEN: begin
        m_len = {m_len[23:0], b};
        m_idx++;
        if (m_idx >= 4) begin m_phase = P_TYPE; m_idx = 0; m_crc = CRC_INIT; end
        if (last) push_status(ST_BAD_CHK, 1'b1);
      end
      P_TYPE: begin
        m_type = {m_type[23:0], b};
        m_crc = crc_step(m_crc, b);
        m_idx++;
        if (m_idx >= 4) begin
          m_pending = (m_type == T_IDAT) ? idat_verdict() : 3'd0;
          m_phase = (m_len != 0) ? P_DATA : P_CRC;
          m_idx = 0;
        end
        if (last) push_status(ST_BAD_CHK, 1'b1);
      end
      P_DATA: begin
        m_crc = crc_step(m_crc, b);
        if (m_type == T_IHDR && !f_hdr && m_idx < 13) m_hdr[m_idx] = b;
        pass = m_type == T_IDAT && m_pending == 0 && m_copy;
        m_idx++;
        if (m_idx >= m_len) begin m_phase = P_CRC; m_idx = 0; end
        if (last) push_status(ST_BAD_CHK, 1'b1);
        else if (pass) begin
          r.kind = 1'b0;
          r.data = '0;
          r.data[7:0] = b;
          expected_results.push_back(r);
        end
      end
      P_CRC: begin
        m_stored = {m_stored[23:0], b};
        m_idx++;
        if (m_idx < 4) begin
          if (last) push_status(ST_BAD_CHK, 1'b1);
        end else begin
          st = chunk_verdict();
          if (st != ST_OK) push_status(st, last);
          else if (m_type == T_IEND) begin
            if (!last) push_status(ST_BAD_CHK, 1'b0);
            else if (m_payload == 0 ||
                     (m_hdr[9] == 3 && (!f_pal || m_alpha > m_pal)))
              push_status(ST_BAD_CHK, 1'b1);
            else push_status(ST_OK, 1'b1);
          end else if (last) push_status(ST_BAD_CHK, 1'b1);
          else begin
            m_phase = P_LEN; m_idx = 0; m_len = 0; m_type = 0; m_stored = 0;
            m_pending = 0;
          end
        end
      end
      default: if (last) restart_parser();
    endcase
  endtask

  task automatic report_mismatch(string what, logic [151:0] got, logic [151:0] want);
    error_count++;
    $display("%0t: mismatch in %s: got %h expected %h", $realtime, what, got, want);
  endtask

  // driver: presents queued bytes, random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_accepted) begin
      if (in_tvalid) void'(byte_queue.pop_front());
      if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= byte_queue[0][7:0];
        in_tlast <= byte_queue[0][8];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // input monitor feeds the predictor at the accepting edge
  always @(posedge clk) begin
    in_accepted = rst_n && in_tvalid && in_tready;
    if (in_accepted) predict_byte(in_tdata, in_tlast);
  end

  // output monitor compares against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata, '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tuser !== want.kind)
          report_mismatch("kind", {151'd0, out_tuser}, {151'd0, want.kind});
        if (out_tdata[7:0] !== want.data[7:0])
          report_mismatch("payload_byte", out_tdata, want.data);
        if (out_tdata[10:8] !== want.data[10:8])
          report_mismatch("status", out_tdata, want.data);
        if (out_tdata[94:11] !== want.data[94:11])
          report_mismatch("header fields", out_tdata, want.data);
        if (out_tdata[144:95] !== want.data[144:95])
          report_mismatch("counts", out_tdata, want.data);
        if (out_tdata[151:145] !== want.data[151:145])
          report_mismatch("padding", out_tdata, want.data);
      end
    end
  end

  // configuration write: setup then access
  task automatic write_reg(logic [2:0] addr, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= addr; cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == 3'd0) m_copy = value[0];
    else m_cap = value;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic push_bytes(logic [7:0] bytes[$], logic last_at_end);
    foreach (bytes[i]) byte_queue.push_back({last_at_end && i == bytes.size() - 1, bytes[i]});
  endtask

  // build one chunk with length, type, data and crc
  function automatic void add_chunk(ref logic [7:0] f[$], input logic [31:0] ty,
                                    input logic [7:0] body[$], input logic bad_crc);
    logic [31:0] c;
    c = CRC_INIT;
    for (int i = 3; i >= 0; i--) f.push_back(8'(body.size() >> (8 * i)));
    for (int i = 3; i >= 0; i--) begin f.push_back(ty[8*i +: 8]); c = crc_step(c, ty[8*i +: 8]); end
    foreach (body[i]) begin f.push_back(body[i]); c = crc_step(c, body[i]); end
    c = c ^ CRC_INIT;
    if (bad_crc) c[$urandom_range(31)] ^= 1'b1;
    for (int i = 3; i >= 0; i--) f.push_back(c[8*i +: 8]);
  endfunction

  function automatic void ihdr_body(ref logic [7:0] b[$], input logic [31:0] w,
                                    input logic [31:0] h, input logic [7:0] d,
                                    input logic [7:0] ct, input logic [7:0] il);
    b = {w[31:24], w[23:16], w[15:8], w[7:0], h[31:24], h[23:16], h[15:8], h[7:0],
         d, ct, 8'd0, 8'd0, il};
  endfunction

  // one random file, mostly well formed
  task automatic random_file(int mode);
    logic [7:0] f[$], body[$];
    logic [7:0] cts[5], ct, d;
    int n_idat, k;
    logic [31:0] ty;
    cts = '{8'd0, 8'd2, 8'd3, 8'd4, 8'd6};
    f = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    if (mode == 0) begin
      // pure noise
      f.delete();
      k = $urandom_range(1, 20);
      repeat (k) f.push_back(8'($urandom));
      push_bytes(f, 1'b1);
      return;
    end
    ct = cts[$urandom_range(4)];
    d = (ct == 3) ? (8'd1 << $urandom_range(3)) : (($urandom_range(1)) ? 8'd8 : 8'd16);
    if (ct == 0 && $urandom_range(1)) d = 8'd1 << $urandom_range(3);
    if ($urandom_range(15) == 0) d = 8'($urandom);
    ihdr_body(body, ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 300),
              ($urandom_range(7) == 0) ? $urandom : $urandom_range(1, 300), d, ct,
              ($urandom_range(15) == 0) ? 8'd2 : 8'($urandom_range(1)));
    add_chunk(f, T_IHDR, body, $urandom_range(30) == 0);
    if (ct == 3 || ((ct == 2 || ct == 6) && $urandom_range(1))) begin
      body.delete();
      k = (ct == 3) ? $urandom_range(1, (d >= 8) ? 12 : (1 << d)) : $urandom_range(1, 8);
      repeat (3 * k) body.push_back(8'($urandom));
      add_chunk(f, T_PLTE, body, 1'b0);
      if ($urandom_range(2) == 0) begin
        body.delete();
        repeat ($urandom_range(1, k)) body.push_back(8'($urandom));
        add_chunk(f, T_TRNS, body, 1'b0);
      end
    end else if (ct == 0 && $urandom_range(2) == 0) begin
      body = {8'($urandom), 8'($urandom)};
      add_chunk(f, T_TRNS, body, 1'b0);
    end
    if ($urandom_range(5) == 0) begin
      body = {8'($urandom), 8'($urandom)};
      ty = $urandom | 32'h2000_0000;
      add_chunk(f, ty, body, 1'b0);
    end
    n_idat = $urandom_range(mode == 2 ? 0 : 1, 3);
    repeat (n_idat) begin
      body.delete();
      repeat ($urandom_range(0, 30)) body.push_back(8'($urandom));
      add_chunk(f, T_IDAT, body, $urandom_range(25) == 0);
    end
    if (mode == 2 && $urandom_range(1)) begin
      body.delete();
      add_chunk(f, $urandom, body, 1'b0);
    end
    body.delete();
    add_chunk(f, T_IEND, body, 1'b0);
    if (mode == 3) begin
      // truncation or trailing bytes
      if ($urandom_range(1)) begin
        k = $urandom_range(1, f.size() - 1);
        while (f.size() > k) void'(f.pop_back());
      end else begin
        repeat ($urandom_range(1, 4)) f.push_back(8'($urandom));
      end
    end
    if (mode == 4) f[$urandom_range(f.size() - 1)] ^= 8'd1 << $urandom_range(7);
    push_bytes(f, 1'b1);
  endtask

  task automatic drain();
    while (byte_queue.size() > 0 || in_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(int n_files);
    int m;
    repeat (n_files) begin
      m = $urandom_range(99);
      random_file(m < 6 ? 0 : m < 14 ? 2 : m < 24 ? 3 : m < 32 ? 4 : 1);
    end
    drain();
  endtask

  initial begin
    logic [7:0] f[$], body[$];
    error_count = 0;
    results_seen = 0;
    send_idle_pct = 19;
    recv_idle_pct = 80;
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = 8'd0; in_tlast = 1'b0; out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0; cfg_paddr = 3'd0; cfg_pwdata = 0;
    m_copy = 1'b0; m_cap = 32'd0;
    restart_parser();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: minimal valid file with copying and a large capacity
    write_reg(3'd0, 32'd1);
    write_reg(3'd4, 32'hFFFF_FFFF);
    f = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    ihdr_body(body, 32'd1, 32'd1, 8'd8, 8'd0, 8'd1);
    add_chunk(f, T_IHDR, body, 1'b0);
    body = {8'h00, 8'hFF, 8'h5A};
    add_chunk(f, T_IDAT, body, 1'b0);
    body.delete();
    add_chunk(f, T_IEND, body, 1'b0);
    push_bytes(f, 1'b1);
    // bad signature, early last, and a lone last byte
    byte_queue.push_back({1'b0, 8'h88});
    byte_queue.push_back({1'b1, 8'hFF});
    byte_queue.push_back({1'b1, 8'h89});
    f = {8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    push_bytes(f, 1'b1);
    drain();

    // capacity zero rejects any payload
    write_reg(3'd4, 32'd0);
    run_phase(2);
    write_reg(3'd4, 32'd40);
    run_phase(6);
    write_reg(3'd0, 32'd0);
    send_idle_pct = 80;
    recv_idle_pct = 19;
    run_phase(6);
    write_reg(3'd0, 32'd1);
    write_reg(3'd4, 32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(5);

    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
